@@ hw/rtl/cau_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types and constants of the complex arithmetic unit: function and
// status codes, angle accumulator format and the arctangent table.
// ----------------------------------------------------------------------------
package cau_pkg;

	typedef enum logic [2:0] {
		FUNC_ADD = 3'd0,
		FUNC_SUB = 3'd1,
		FUNC_MUL = 3'd2,
		FUNC_DIV = 3'd3,
		FUNC_EQ  = 3'd4,
		FUNC_REQ = 3'd5,
		FUNC_MAG = 3'd6,
		FUNC_ANG = 3'd7
	} cau_func_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_SAT  = 2'd1,
		ST_DIVZ = 2'd2
	} cau_status_t;

	// angle accumulator: degrees scaled by 2^16
	localparam int ZW          = 26;
	localparam int ANG_SCALE   = 16;
	localparam int ANGLE_SHIFT = 10;
	localparam logic signed [ZW-1:0] DEG_90    = 26'sd5898240;
	localparam logic signed [ZW-1:0] ANG_ROUND = 26'sd512;

	function automatic logic signed [ZW-1:0] cau_atan(input logic [4:0] idx);
		logic signed [ZW-1:0] v;
		case (idx)
			5'd0:    v = 26'sd2949120;
			5'd1:    v = 26'sd1740967;
			5'd2:    v = 26'sd919879;
			5'd3:    v = 26'sd466945;
			5'd4:    v = 26'sd234379;
			5'd5:    v = 26'sd117304;
			5'd6:    v = 26'sd58666;
			5'd7:    v = 26'sd29335;
			5'd8:    v = 26'sd14668;
			5'd9:    v = 26'sd7334;
			5'd10:   v = 26'sd3667;
			5'd11:   v = 26'sd1833;
			5'd12:   v = 26'sd917;
			5'd13:   v = 26'sd458;
			5'd14:   v = 26'sd229;
			5'd15:   v = 26'sd115;
			5'd16:   v = 26'sd57;
			5'd17:   v = 26'sd29;
			5'd18:   v = 26'sd14;
			5'd19:   v = 26'sd7;
			5'd20:   v = 26'sd4;
			5'd21:   v = 26'sd2;
			5'd22:   v = 26'sd1;
			default: v = 26'sd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/complex_arithmetic_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Fixed-point complex ALU: add, subtract, multiply, divide, compares,
// magnitude and CORDIC angle of signed Q8.8 operands, fully pipelined.
//
//   channel   signals                                 direction  handshake
//   request   start, busy, func, a_re, a_im,          in         start & !busy
//             b_re, b_im
//   result    done, res_re, res_im, equal_flag,       out        done strobe
//             status
//
// one request per cycle; busy stays low
// results pass the request, product and sum registers, then the units and their side band
// delay, whose depth is set by the bit-per-stage divider and the CORDIC stage chain
// arst_n clears the valid bits only; no other state
// results leave on done for one cycle and are never held back
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
	parameter int DATA_WIDTH   = 16,
	parameter int FRAC_BITS    = 8,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [2:0]                   func,
	input  logic signed [DATA_WIDTH-1:0] a_re,
	input  logic signed [DATA_WIDTH-1:0] a_im,
	input  logic signed [DATA_WIDTH-1:0] b_re,
	input  logic signed [DATA_WIDTH-1:0] b_im,
	output logic                         done,
	output logic signed [DATA_WIDTH-1:0] res_re,
	output logic signed [DATA_WIDTH-1:0] res_im,
	output logic                         equal_flag,
	output logic [1:0]                   status
);
	import cau_pkg::*;

	localparam int W       = DATA_WIDTH;
	localparam int DIV_LAT = W + 2;
	localparam int CRD_LAT = CORDIC_STEPS + 1;
	localparam int P       = (DIV_LAT > CRD_LAT) ? DIV_LAT : CRD_LAT;
	localparam int EW0     = 2 * W + FRAC_BITS + 2;
	localparam int EW      = (EW0 > ZW) ? EW0 : ZW;
	localparam logic signed [EW-1:0] MAXE = EW'((64'sd1 <<< (W - 1)) - 64'sd1);
	localparam logic signed [EW-1:0] MINE = -MAXE - EW'(1);
	localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};

	function automatic logic [W:0] clamp_w(input logic signed [EW-1:0] v);
		logic [W:0] r;
		if (v > MAXE) begin
			r = {1'b1, MAXE[W-1:0]};
		end else if (v < MINE) begin
			r = {1'b1, MINE[W-1:0]};
		end else begin
			r = {1'b0, v[W-1:0]};
		end
		return r;
	endfunction

	assign busy = 1'b0;

	// stage 1: request register
	logic                valid_s1;
	cau_func_t           func_s1;
	logic signed [W-1:0] ar_s1, ai_s1, br_s1, bi_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		func_s1 <= cau_func_t'(func);
		ar_s1   <= a_re;
		ai_s1   <= a_im;
		br_s1   <= b_re;
		bi_s1   <= b_im;
	end

	// stage 2: products
	logic                  valid_s2;
	cau_func_t             func_s2;
	logic signed [W-1:0]   ar_s2, ai_s2, br_s2, bi_s2;
	logic signed [2*W-1:0] p_rr_s2, p_ii_s2, p_ir_s2, p_ri_s2;
	logic signed [2*W-1:0] p_bbr_s2, p_bbi_s2, p_aar_s2, p_aai_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		func_s2  <= func_s1;
		ar_s2    <= ar_s1;
		ai_s2    <= ai_s1;
		br_s2    <= br_s1;
		bi_s2    <= bi_s1;
		p_rr_s2  <= ar_s1 * br_s1;
		p_ii_s2  <= ai_s1 * bi_s1;
		p_ir_s2  <= ai_s1 * br_s1;
		p_ri_s2  <= ar_s1 * bi_s1;
		p_bbr_s2 <= br_s1 * br_s1;
		p_bbi_s2 <= bi_s1 * bi_s1;
		p_aar_s2 <= ar_s1 * ar_s1;
		p_aai_s2 <= ai_s1 * ai_s1;
	end

	// stage 3: sums, direct results, divider, root and CORDIC operands
	logic signed [2*W:0] mre, mim, nre, nim;
	logic signed [2*W:0] nre_abs, nim_abs;
	logic [2*W-1:0]      den_c, sq_c;
	logic [W:0]          cre, cim;
	logic                flag_c;

	assign mre     = (2*W+1)'(p_rr_s2) - (2*W+1)'(p_ii_s2);
	assign mim     = (2*W+1)'(p_ir_s2) + (2*W+1)'(p_ri_s2);
	assign nre     = (2*W+1)'(p_rr_s2) + (2*W+1)'(p_ii_s2);
	assign nim     = (2*W+1)'(p_ir_s2) - (2*W+1)'(p_ri_s2);
	assign nre_abs = (nre < 0) ? -nre : nre;
	assign nim_abs = (nim < 0) ? -nim : nim;
	assign den_c   = $unsigned(p_bbr_s2) + $unsigned(p_bbi_s2);
	assign sq_c    = $unsigned(p_aar_s2) + $unsigned(p_aai_s2);

	always_comb begin
		cre    = '0;
		cim    = '0;
		flag_c = 1'b0;
		case (func_s2)
			FUNC_ADD: begin
				cre = clamp_w(EW'(ar_s2) + EW'(br_s2));
				cim = clamp_w(EW'(ai_s2) + EW'(bi_s2));
			end
			FUNC_SUB: begin
				cre = clamp_w(EW'(ar_s2) - EW'(br_s2));
				cim = clamp_w(EW'(ai_s2) - EW'(bi_s2));
			end
			FUNC_MUL: begin
				cre = clamp_w(EW'(mre >>> FRAC_BITS));
				cim = clamp_w(EW'(mim >>> FRAC_BITS));
			end
			FUNC_EQ:  flag_c = (ar_s2 == br_s2) && (ai_s2 == bi_s2);
			FUNC_REQ: flag_c = (ar_s2 == br_s2);
			default: begin
				cre = '0;
				cim = '0;
			end
		endcase
	end

	logic                valid_s3;
	cau_func_t           func_s3;
	logic [W-1:0]        dre_s3, dim_s3;
	logic                dflag_s3, dsat_s3, dz_s3;
	logic                nre_neg_s3, nim_neg_s3;
	logic [2*W-1:0]      nre_mag_s3, nim_mag_s3, den_s3, sq_s3;
	logic signed [W-1:0] ar_s3, ai_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		func_s3    <= func_s2;
		dre_s3     <= cre[W-1:0];
		dim_s3     <= cim[W-1:0];
		dsat_s3    <= cre[W] | cim[W];
		dflag_s3   <= flag_c;
		dz_s3      <= (den_c == '0);
		nre_neg_s3 <= nre[2*W];
		nim_neg_s3 <= nim[2*W];
		nre_mag_s3 <= nre_abs[2*W-1:0];
		nim_mag_s3 <= nim_abs[2*W-1:0];
		den_s3     <= den_c;
		sq_s3      <= sq_c;
		ar_s3      <= ar_s2;
		ai_s3      <= ai_s2;
	end

	// iterative units, all P stages deep
	logic signed [W-1:0]  qre, qim;
	logic                 qre_sat, qim_sat;
	logic [W-1:0]         root;
	logic signed [ZW-1:0] zang;
	logic                 zzero;

	cau_div #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS), .DEPTH(P)) u_div_re (
		.clk(clk), .mag(nre_mag_s3), .neg(nre_neg_s3), .den(den_s3),
		.quo(qre), .sat(qre_sat)
	);

	cau_div #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS), .DEPTH(P)) u_div_im (
		.clk(clk), .mag(nim_mag_s3), .neg(nim_neg_s3), .den(den_s3),
		.quo(qim), .sat(qim_sat)
	);

	cau_sqrt #(.DATA_WIDTH(W), .DEPTH(P)) u_sqrt (
		.clk(clk), .s(sq_s3), .root(root)
	);

	cau_cordic #(.DATA_WIDTH(W), .STEPS(CORDIC_STEPS), .DEPTH(P)) u_cordic (
		.clk(clk), .re(ar_s3), .im(ai_s3), .z(zang), .zero(zzero)
	);

	// side band delay alongside the units
	logic         vld_sd   [P];
	cau_func_t    fn_sd    [P];
	logic [W-1:0] dre_sd   [P];
	logic [W-1:0] dim_sd   [P];
	logic         dflag_sd [P];
	logic         dsat_sd  [P];
	logic         dz_sd    [P];

	for (genvar k = 0; k < P; k++) begin : g_delay
		if (k == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_sd[k] <= 1'b0;
				end else begin
					vld_sd[k] <= valid_s3;
				end
			end
			always_ff @(posedge clk) begin
				fn_sd[k]    <= func_s3;
				dre_sd[k]   <= dre_s3;
				dim_sd[k]   <= dim_s3;
				dflag_sd[k] <= dflag_s3;
				dsat_sd[k]  <= dsat_s3;
				dz_sd[k]    <= dz_s3;
			end
		end else begin : g_next
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_sd[k] <= 1'b0;
				end else begin
					vld_sd[k] <= vld_sd[k-1];
				end
			end
			always_ff @(posedge clk) begin
				fn_sd[k]    <= fn_sd[k-1];
				dre_sd[k]   <= dre_sd[k-1];
				dim_sd[k]   <= dim_sd[k-1];
				dflag_sd[k] <= dflag_sd[k-1];
				dsat_sd[k]  <= dsat_sd[k-1];
				dz_sd[k]    <= dz_sd[k-1];
			end
		end
	end

	// output select
	logic signed [ZW-1:0] ang_r;
	logic [W:0]           ang_c;
	logic [W-1:0]         o_re, o_im;
	logic                 o_flag;
	cau_status_t          o_st;

	assign ang_r = (zang + ANG_ROUND) >>> ANGLE_SHIFT;
	assign ang_c = clamp_w(EW'(ang_r));

	always_comb begin
		o_re   = dre_sd[P-1];
		o_im   = dim_sd[P-1];
		o_flag = dflag_sd[P-1];
		o_st   = dsat_sd[P-1] ? ST_SAT : ST_OK;
		case (fn_sd[P-1])
			FUNC_DIV: begin
				if (dz_sd[P-1]) begin
					o_re = '0;
					o_im = '0;
					o_st = ST_DIVZ;
				end else begin
					o_re = qre;
					o_im = qim;
					o_st = (qre_sat | qim_sat) ? ST_SAT : ST_OK;
				end
			end
			FUNC_MAG: begin
				o_re = root[W-1] ? MAXV : root;
				o_im = '0;
				o_st = root[W-1] ? ST_SAT : ST_OK;
			end
			FUNC_ANG: begin
				o_re = zzero ? '0 : ang_c[W-1:0];
				o_im = '0;
				o_st = (!zzero && ang_c[W]) ? ST_SAT : ST_OK;
			end
			default: o_flag = dflag_sd[P-1];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_sd[P-1];
		end
	end

	always_ff @(posedge clk) begin
		res_re     <= o_re;
		res_im     <= o_im;
		equal_flag <= o_flag;
		status     <= o_st;
	end

	a_divz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_DIVZ) |-> (res_re == 0 && res_im == 0))
		else $error("division by zero result not zero");

	a_flag_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && equal_flag) |-> (status == ST_OK && res_re == 0 && res_im == 0))
		else $error("compare result carries data or status");

	a_sat_edge: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_SAT) |->
		(res_re == MAXE[W-1:0] || res_re == MINE[W-1:0] ||
		 res_im == MAXE[W-1:0] || res_im == MINE[W-1:0]))
		else $error("saturated status without a clamped part");

endmodule
`default_nettype wire

@@ hw/rtl/cau_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_div
// Pipelined restoring divider, one quotient bit per stage. Divides
// magnitude * 2^FRAC_BITS by den, truncates toward zero, applies the sign
// and saturates to the signed data range.
// ----------------------------------------------------------------------------
module cau_div #(
	parameter int DATA_WIDTH = 16,
	parameter int FRAC_BITS  = 8,
	parameter int DEPTH      = 18
) (
	input  logic                         clk,
	input  logic [2*DATA_WIDTH-1:0]      mag,
	input  logic                         neg,
	input  logic [2*DATA_WIDTH-1:0]      den,
	output logic signed [DATA_WIDTH-1:0] quo,
	output logic                         sat
);
	localparam int W    = DATA_WIDTH;
	localparam int NW   = 2 * W + FRAC_BITS;
	localparam int HW   = NW - W - 1;
	localparam int CMPW = (HW > 2 * W) ? HW : 2 * W;
	localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

	logic [2*W-1:0] rem_s [DEPTH];
	logic [2*W-1:0] den_s [DEPTH];
	logic [W:0]     lo_s  [DEPTH];
	logic [W:0]     q_s   [DEPTH];
	logic           ovf_s [DEPTH];
	logic           neg_s [DEPTH];

	logic [NW-1:0]   dfull;
	logic [CMPW-1:0] hi_ext;
	logic [CMPW-1:0] den_ext;

	assign dfull   = NW'(mag) << FRAC_BITS;
	assign hi_ext  = CMPW'(dfull[NW-1:W+1]);
	assign den_ext = CMPW'(den);

	// stage 0: load the remainder and flag a quotient too large for W+1 bits
	always_ff @(posedge clk) begin
		rem_s[0] <= hi_ext[2*W-1:0];
		den_s[0] <= den;
		lo_s[0]  <= dfull[W:0];
		q_s[0]   <= '0;
		ovf_s[0] <= (hi_ext >= den_ext);
		neg_s[0] <= neg;
	end

	for (genvar j = 1; j < DEPTH; j++) begin : g_stage
		if (j <= W + 1) begin : g_step
			logic [2*W:0] trial;
			logic [2*W:0] diff;
			assign trial = {rem_s[j-1], lo_s[j-1][W]};
			assign diff  = trial - {1'b0, den_s[j-1]};
			always_ff @(posedge clk) begin
				if (trial >= {1'b0, den_s[j-1]}) begin
					rem_s[j] <= diff[2*W-1:0];
					q_s[j]   <= {q_s[j-1][W-1:0], 1'b1};
				end else begin
					rem_s[j] <= trial[2*W-1:0];
					q_s[j]   <= {q_s[j-1][W-1:0], 1'b0};
				end
				lo_s[j]  <= {lo_s[j-1][W-1:0], 1'b0};
				den_s[j] <= den_s[j-1];
				ovf_s[j] <= ovf_s[j-1];
				neg_s[j] <= neg_s[j-1];
			end
		end else begin : g_pass
			always_ff @(posedge clk) begin
				rem_s[j] <= rem_s[j-1];
				q_s[j]   <= q_s[j-1];
				lo_s[j]  <= lo_s[j-1];
				den_s[j] <= den_s[j-1];
				ovf_s[j] <= ovf_s[j-1];
				neg_s[j] <= neg_s[j-1];
			end
		end
	end

	logic [W:0]   q;
	logic [W-1:0] qn;
	assign q  = q_s[DEPTH-1];
	assign qn = '0 - q[W-1:0];

	always_comb begin
		if (ovf_s[DEPTH-1]) begin
			sat = 1'b1;
			quo = neg_s[DEPTH-1] ? MINV : MAXV;
		end else if (!neg_s[DEPTH-1]) begin
			sat = q[W] | q[W-1];
			quo = sat ? MAXV : q[W-1:0];
		end else begin
			sat = q[W] | (q[W-1] & (|q[W-2:0]));
			quo = sat ? MINV : qn;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/cau_sqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_sqrt
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Gives the floor of the square root of a 2*DATA_WIDTH bit value.
// ----------------------------------------------------------------------------
module cau_sqrt #(
	parameter int DATA_WIDTH = 16,
	parameter int DEPTH      = 18
) (
	input  logic                    clk,
	input  logic [2*DATA_WIDTH-1:0] s,
	output logic [DATA_WIDTH-1:0]   root
);
	localparam int W = DATA_WIDTH;

	logic [W+1:0]   rem_s  [DEPTH];
	logic [W-1:0]   root_s [DEPTH];
	logic [2*W-1:0] sh_s   [DEPTH];

	for (genvar j = 0; j < DEPTH; j++) begin : g_stage
		logic [W+1:0]   rem_p;
		logic [W-1:0]   root_p;
		logic [2*W-1:0] sh_p;
		if (j == 0) begin : g_first
			assign rem_p  = '0;
			assign root_p = '0;
			assign sh_p   = s;
		end else begin : g_next
			assign rem_p  = rem_s[j-1];
			assign root_p = root_s[j-1];
			assign sh_p   = sh_s[j-1];
		end
		if (j < W) begin : g_step
			logic [W+3:0] t;
			logic [W+3:0] trial;
			logic [W+3:0] diff;
			assign t     = {rem_p, sh_p[2*W-1 -: 2]};
			assign trial = (W+4)'({root_p, 2'b01});
			assign diff  = t - trial;
			always_ff @(posedge clk) begin
				if (t >= trial) begin
					rem_s[j]  <= diff[W+1:0];
					root_s[j] <= {root_p[W-2:0], 1'b1};
				end else begin
					rem_s[j]  <= t[W+1:0];
					root_s[j] <= {root_p[W-2:0], 1'b0};
				end
				sh_s[j] <= sh_p << 2;
			end
		end else begin : g_pass
			always_ff @(posedge clk) begin
				rem_s[j]  <= rem_p;
				root_s[j] <= root_p;
				sh_s[j]   <= sh_p;
			end
		end
	end

	assign root = root_s[DEPTH-1];

endmodule
`default_nettype wire

@@ hw/rtl/cau_cordic.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_cordic
// Pipelined CORDIC in vectoring mode: a quadrant fold stage, then one
// micro-rotation per stage. Gives the angle of (re, im) in degrees * 2^16.
// ----------------------------------------------------------------------------
module cau_cordic #(
	parameter int DATA_WIDTH = 16,
	parameter int STEPS      = 16,
	parameter int DEPTH      = 18
) (
	input  logic                            clk,
	input  logic signed [DATA_WIDTH-1:0]    re,
	input  logic signed [DATA_WIDTH-1:0]    im,
	output logic signed [cau_pkg::ZW-1:0]   z,
	output logic                            zero
);
	import cau_pkg::*;

	localparam int CW = DATA_WIDTH + ANG_SCALE + 3;

	logic signed [CW-1:0] x_s    [DEPTH];
	logic signed [CW-1:0] y_s    [DEPTH];
	logic signed [ZW-1:0] z_s    [DEPTH];
	logic                 zero_s [DEPTH];

	logic signed [CW-1:0] xi;
	logic signed [CW-1:0] yi;
	assign xi = CW'(re) <<< ANG_SCALE;
	assign yi = CW'(im) <<< ANG_SCALE;

	// fold into the right half plane
	always_ff @(posedge clk) begin
		if (re < 0) begin
			if (im >= 0) begin
				x_s[0] <= yi;
				y_s[0] <= -xi;
				z_s[0] <= DEG_90;
			end else begin
				x_s[0] <= -yi;
				y_s[0] <= xi;
				z_s[0] <= -DEG_90;
			end
		end else begin
			x_s[0] <= xi;
			y_s[0] <= yi;
			z_s[0] <= '0;
		end
		zero_s[0] <= (re == 0) && (im == 0);
	end

	for (genvar j = 1; j < DEPTH; j++) begin : g_stage
		if (j <= STEPS) begin : g_step
			logic signed [CW-1:0] xs;
			logic signed [CW-1:0] ys;
			logic signed [ZW-1:0] at;
			assign xs = x_s[j-1] >>> (j - 1);
			assign ys = y_s[j-1] >>> (j - 1);
			assign at = cau_atan(5'(j - 1));
			always_ff @(posedge clk) begin
				if (y_s[j-1] >= 0) begin
					x_s[j] <= x_s[j-1] + ys;
					y_s[j] <= y_s[j-1] - xs;
					z_s[j] <= z_s[j-1] + at;
				end else begin
					x_s[j] <= x_s[j-1] - ys;
					y_s[j] <= y_s[j-1] + xs;
					z_s[j] <= z_s[j-1] - at;
				end
				zero_s[j] <= zero_s[j-1];
			end
		end else begin : g_pass
			always_ff @(posedge clk) begin
				x_s[j]    <= x_s[j-1];
				y_s[j]    <= y_s[j-1];
				z_s[j]    <= z_s[j-1];
				zero_s[j] <= zero_s[j-1];
			end
		end
	end

	assign z    = z_s[DEPTH-1];
	assign zero = zero_s[DEPTH-1];

endmodule
`default_nettype wire

@@ tb/cau_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_checker
// Watches the request and result channels of the complex arithmetic unit,
// computes the expected result of every accepted request and compares each
// result in order against it.
// ----------------------------------------------------------------------------
module cau_checker
	import cau_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [2:0]         func,
	input  logic signed [15:0] a_re,
	input  logic signed [15:0] a_im,
	input  logic signed [15:0] b_re,
	input  logic signed [15:0] b_im,
	input  logic               done,
	input  logic signed [15:0] res_re,
	input  logic signed [15:0] res_im,
	input  logic               equal_flag,
	input  logic [1:0]         status,
	output int                 errors,
	output int                 pending
);

	typedef struct packed {
		logic signed [15:0] re;
		logic signed [15:0] im;
		logic               flag;
		logic [1:0]         st;
	} cau_result_t;

	cau_result_t result_q[$];

	localparam longint HI = 32767;
	localparam longint LO = -32768;

	function automatic longint sat16(input longint v, inout bit sat);
		if (v > HI) begin
			sat = 1;
			return HI;
		end
		if (v < LO) begin
			sat = 1;
			return LO;
		end
		return v;
	endfunction

	function automatic longint fshr(input longint v, input int s);
		return v >>> s;
	endfunction

	function automatic longint root_floor(input longint s);
		longint r;
		longint b;
		r = 0;
		b = 64'sd1 <<< 62;
		while (b > s) b = b >>> 2;
		while (b != 0) begin
			if (s >= r + b) begin
				s = s - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		return r;
	endfunction

	function automatic longint angle_deg(input longint re, input longint im);
		longint x, y, z, t, xs, ys;
		if (re == 0 && im == 0) return 0;
		x = re * 65536;
		y = im * 65536;
		z = 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				z = DEG_90;
			end else begin
				x = -y;
				y = t;
				z = -DEG_90;
			end
		end
		for (int i = 0; i < 16; i++) begin
			xs = fshr(x, i);
			ys = fshr(y, i);
			if (y >= 0) begin
				x += ys;
				y -= xs;
				z += longint'(cau_atan(5'(i)));
			end else begin
				x -= ys;
				y += xs;
				z -= longint'(cau_atan(5'(i)));
			end
		end
		return fshr(z + 512, ANGLE_SHIFT);
	endfunction

	function automatic cau_result_t compute_result(input logic [2:0] f,
			input longint ar, input longint ai, input longint br, input longint bi);
		cau_result_t r;
		longint re, im, den;
		bit sat;
		re = 0;
		im = 0;
		sat = 0;
		r.flag = 0;
		r.st = ST_OK;
		case (cau_func_t'(f))
			FUNC_ADD: begin
				re = sat16(ar + br, sat);
				im = sat16(ai + bi, sat);
			end
			FUNC_SUB: begin
				re = sat16(ar - br, sat);
				im = sat16(ai - bi, sat);
			end
			FUNC_MUL: begin
				re = sat16(fshr(ar * br - ai * bi, 8), sat);
				im = sat16(fshr(ai * br + ar * bi, 8), sat);
			end
			FUNC_DIV: begin
				den = br * br + bi * bi;
				if (den == 0) begin
					r.st = ST_DIVZ;
				end else begin
					re = sat16(((ar * br + ai * bi) * 256) / den, sat);
					im = sat16(((ai * br - ar * bi) * 256) / den, sat);
				end
			end
			FUNC_EQ:  r.flag = (ar == br && ai == bi);
			FUNC_REQ: r.flag = (ar == br);
			FUNC_MAG: re = sat16(root_floor(ar * ar + ai * ai), sat);
			default:  re = sat16(angle_deg(ar, ai), sat);
		endcase
		if (sat && r.st == ST_OK) r.st = ST_SAT;
		r.re = re[15:0];
		r.im = im[15:0];
		return r;
	endfunction

	assign pending = result_q.size();

	initial errors = 0;

	always @(posedge clk) begin
		cau_result_t e;
		if (arst_n && start && !busy)
			result_q.push_back(compute_result(func, a_re, a_im, b_re, b_im));
		if (arst_n && done) begin
			if (result_q.size() == 0) begin
				$display("%0t unexpected result re=%0d im=%0d", $time, res_re, res_im);
				errors++;
			end else begin
				e = result_q.pop_front();
				if (res_re !== e.re || res_im !== e.im || equal_flag !== e.flag
						|| status !== e.st) begin
					$display("%0t mismatch: expected re=%0d im=%0d eq=%0d st=%0d, actual re=%0d im=%0d eq=%0d st=%0d",
						$time, e.re, e.im, e.flag, e.st, res_re, res_im, equal_flag, status);
					errors++;
				end
			end
		end
	end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random requests into the complex arithmetic unit
// under several idle patterns; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;
	import cau_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [2:0]         func;
	logic signed [15:0] a_re, a_im, b_re, b_im;
	logic               done;
	logic signed [15:0] res_re, res_im;
	logic               equal_flag;
	logic [1:0]         status;
	int                 errors;
	int                 pending;
	int                 idle_pct;
	int                 quiet;

	localparam int WATCHDOG = 2000;

	complex_arithmetic_unit uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im), .done(done),
		.res_re(res_re), .res_im(res_im), .equal_flag(equal_flag), .status(status)
	);

	cau_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im), .done(done),
		.res_re(res_re), .res_im(res_im), .equal_flag(equal_flag), .status(status),
		.errors(errors), .pending(pending)
	);

	initial clk = 0;
	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= WATCHDOG) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic logic [15:0] pick_val();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'(int'($urandom_range(0, 1024)) - 512);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_request(input logic [2:0] f, input logic [15:0] ar,
			input logic [15:0] ai, input logic [15:0] br, input logic [15:0] bi);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		func <= f;
		a_re <= ar;
		a_im <= ai;
		b_re <= br;
		b_im <= bi;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic send_random();
		logic [15:0] ar, ai, br, bi;
		ar = pick_val();
		ai = pick_val();
		br = pick_val();
		bi = pick_val();
		if ($urandom_range(0, 9) == 0) br = ar;
		if ($urandom_range(0, 19) == 0) bi = ai;
		if ($urandom_range(0, 19) == 0) begin
			br = 0;
			bi = 0;
		end
		send_request(3'($urandom_range(0, 7)), ar, ai, br, bi);
	endtask

	task automatic drain();
		start <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		int phase_pct[4];
		phase_pct = '{0, 74, 0, 8};
		quiet = 0;
		idle_pct = 0;
		arst_n = 0;
		start = 0;
		func = FUNC_ADD;
		a_re = 0;
		a_im = 0;
		b_re = 0;
		b_im = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		for (int f = 0; f < 8; f++) begin
			send_request(3'(f), 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
			send_request(3'(f), 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		end
		send_request(FUNC_DIV, 16'h0100, 16'h0100, 16'h0000, 16'h0000);
		send_request(FUNC_DIV, 16'h8000, 16'h0000, 16'h0001, 16'h0000);
		send_request(FUNC_ANG, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_request(FUNC_ANG, 16'hff00, 16'h0000, 16'h0000, 16'h0000);
		send_request(FUNC_ANG, 16'hff00, 16'hff00, 16'h0000, 16'h0000);
		send_request(FUNC_EQ, 16'h0012, 16'h0034, 16'h0012, 16'h0035);
		send_request(FUNC_REQ, 16'h0012, 16'h0034, 16'h0012, 16'h0035);
		send_request(FUNC_MAG, 16'h8000, 16'h0000, 16'h0000, 16'h0000);
		drain();

		for (int p = 0; p < 4; p++) begin
			idle_pct = phase_pct[p];
			repeat (375) send_random();
			drain();
		end

		repeat (40) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/cau_pkg.sv
hw/rtl/cau_div.sv
hw/rtl/cau_sqrt.sv
hw/rtl/cau_cordic.sv
hw/rtl/complex_arithmetic_unit.sv
tb/cau_checker.sv
tb/testbench.sv
